/* src/assert_macros.svh */
// assertion macros shared by the frame allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* src/pfa_pkg.sv */
// shared types and codes of the physical frame allocator
package pfa_pkg;

  // command codes
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_QUERY   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFREE   = 2'd1;
  localparam logic [1:0] ST_BADFRAME = 2'd2;

  // frame count register
  localparam int CFG_W           = 9;
  localparam int FRAME_COUNT_RST = 256;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] process_id;
    logic [19:0] page_number;
    logic [9:0]  frame_number;
  } pfa_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  frame_out;
    logic        frame_used;
    logic [15:0] owner_process;
    logic [19:0] owner_page;
    logic [8:0]  free_frames;
    logic [8:0]  used_frames;
    logic [31:0] allocations_total;
    logic [31:0] releases_total;
  } pfa_out_t;

endpackage

/* src/pfa_free_queue.sv */
// free frame fifo storage with registered read and write forwarding
module pfa_free_queue #(
  parameter int MAX_FRAMES = 256,
  parameter int IDX_W      = $clog2(MAX_FRAMES)
) (
  input  logic             clk,
  input  logic [IDX_W-1:0] rd_addr,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [IDX_W-1:0] wr_data,
  output logic [IDX_W-1:0] rd_data
);

  logic [IDX_W-1:0] mem_r [MAX_FRAMES];
  logic [IDX_W-1:0] rd_mem_r;
  logic [IDX_W-1:0] fwd_data_r;
  logic             fwd_r;

  // storage array, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_mem_r <= mem_r[rd_addr];
  end

  // bypass a write that lands on the address being read
  always_ff @(posedge clk) begin
    fwd_r      <= wr_en && (wr_addr == rd_addr);
    fwd_data_r <= wr_data;
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_mem_r;

endmodule

/* src/pfa_owner_table.sv */
// owner process and page table with registered read and write forwarding
module pfa_owner_table #(
  parameter int MAX_FRAMES = 256,
  parameter int DATA_W     = 36,
  parameter int IDX_W      = $clog2(MAX_FRAMES)
) (
  input  logic              clk,
  input  logic [IDX_W-1:0]  rd_addr,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [MAX_FRAMES];
  logic [DATA_W-1:0] rd_mem_r;
  logic [DATA_W-1:0] fwd_data_r;
  logic              fwd_r;

  // storage array, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_mem_r <= mem_r[rd_addr];
  end

  // bypass a write that lands on the address being read
  always_ff @(posedge clk) begin
    fwd_r      <= wr_en && (wr_addr == rd_addr);
    fwd_data_r <= wr_data;
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_mem_r;

endmodule

/* src/physical_frame_allocator.sv */
// physical page frame allocator with fifo free list, top level
//
// Usage: a command transaction (allocate, release, query) is taken at a
// rising edge with start high and busy low. Every command gives exactly one
// result transaction: out_strobe is high for one cycle with out_item valid.
// A taken command is registered into the stage one register, and its result
// into the output register. Throughput is one command per cycle while busy
// is low; the frame table and free list reads are issued in the accept cycle
// and the update is done in the following cycle, with write forwarding
// between neighbors. The receiver cannot stall, so results are never held.
// cfg_we with cfg_wdata loads the frame count (0 taken as 1, values above
// MAX_FRAMES clipped) and resets pointers and counters in that same edge;
// write it only while no command is in flight.
// Reset does the same with a count of 256 (clipped to MAX_FRAMES).
// busy is high during reset, then after reset and after every frame count
// write until a clearing pass has written all MAX_FRAMES entries, one table
// entry and one free list entry per cycle (frame idle, list in order).
// Free and used counters saturate at the count and at zero; the
// allocation and release totals wrap.
module physical_frame_allocator #(
  parameter int MAX_FRAMES = 256,
  parameter int PID_BITS   = 16,
  parameter int PAGE_BITS  = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  pfa_pkg::pfa_in_t               in_item,
  output logic                           out_strobe,
  output pfa_pkg::pfa_out_t              out_item,
  input  logic                           cfg_we,
  input  logic [pfa_pkg::CFG_W-1:0]      cfg_wdata
);
  import pfa_pkg::*;

`include "assert_macros.svh"

  localparam int IDX_W     = $clog2(MAX_FRAMES);
  localparam int CNT_W     = $clog2(MAX_FRAMES + 1);
  localparam int OWN_W     = PID_BITS + PAGE_BITS;
  localparam int TBL_W     = OWN_W + 1;
  localparam int RST_COUNT = (FRAME_COUNT_RST > MAX_FRAMES) ? MAX_FRAMES : FRAME_COUNT_RST;

  // handshake and pipeline control
  logic                  busy_r;
  logic [IDX_W-1:0]      clr_idx_r;
  logic                  s1_vld_r;
  logic                  out_strobe_r;
  pfa_in_t               s1_item_r;
  pfa_out_t              out_item_r;
  pfa_out_t              res_nxt;

  // allocator state
  logic [CNT_W-1:0]      count_r;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [IDX_W-1:0]      tail_r, tail_nxt;
  logic [CNT_W-1:0]      level_r, level_nxt;
  logic [CNT_W-1:0]      free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0]      used_cnt_r, used_cnt_nxt;
  logic [31:0]           alloc_tot_r, alloc_tot_nxt;
  logic [31:0]           rel_tot_r, rel_tot_nxt;

  // reinit values
  logic [CNT_W-1:0]      init_cnt;
  logic [IDX_W-1:0]      init_tail;

  // memory ports
  logic [IDX_W-1:0]      fq_rd_data;
  logic                  fq_wr_en;
  logic [IDX_W-1:0]      fq_wr_addr;
  logic [IDX_W-1:0]      fq_wr_data;
  logic [TBL_W-1:0]      ot_rd_data;
  logic                  ot_wr_en;
  logic [IDX_W-1:0]      ot_wr_addr;
  logic [TBL_W-1:0]      ot_wr_data;

  // stage one helpers
  logic                  fn_in_range;
  logic                  fn_busy;
  logic [IDX_W-1:0]      fn_idx;
  logic [IDX_W-1:0]      head_inc;
  logic [IDX_W-1:0]      tail_inc;

  // frame count clamp for reset and configuration writes
  always_comb begin
    if (!rst_n) begin
      init_cnt = CNT_W'(RST_COUNT);
    end else if (cfg_wdata == '0) begin
      init_cnt = CNT_W'(1);
    end else if (32'(cfg_wdata) > 32'(MAX_FRAMES)) begin
      init_cnt = CNT_W'(MAX_FRAMES);
    end else begin
      init_cnt = CNT_W'(cfg_wdata);
    end
    init_tail = (32'(init_cnt) == 32'(MAX_FRAMES)) ? '0 : IDX_W'(init_cnt);
  end

  // queue pointer wrap
  assign head_inc = (32'(head_r) == 32'(MAX_FRAMES - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (32'(tail_r) == 32'(MAX_FRAMES - 1)) ? '0 : tail_r + 1'b1;

  assign fn_in_range = 32'(s1_item_r.frame_number) < 32'(count_r);
  assign fn_idx      = IDX_W'(s1_item_r.frame_number);
  assign fn_busy     = ot_rd_data[OWN_W];

  // command execution on the registered transaction
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    level_nxt     = level_r;
    free_cnt_nxt  = free_cnt_r;
    used_cnt_nxt  = used_cnt_r;
    alloc_tot_nxt = alloc_tot_r;
    rel_tot_nxt   = rel_tot_r;
    fq_wr_en      = 1'b0;
    fq_wr_addr    = tail_r;
    fq_wr_data    = fn_idx;
    ot_wr_en      = 1'b0;
    ot_wr_addr    = fn_idx;
    ot_wr_data    = '0;
    res_nxt       = '0;
    res_nxt.status = ST_OK;

    if (s1_vld_r) begin
      unique case (s1_item_r.cmd)
        CMD_ALLOC: begin
          if (free_cnt_r == '0 || level_r == '0) begin
            res_nxt.status = ST_NOFREE;
          end else begin
            head_nxt              = head_inc;
            level_nxt             = level_r - 1'b1;
            ot_wr_en              = 1'b1;
            ot_wr_addr            = fq_rd_data;
            ot_wr_data            = {1'b1, PID_BITS'(s1_item_r.process_id),
                                     PAGE_BITS'(s1_item_r.page_number)};
            free_cnt_nxt          = free_cnt_r - 1'b1;
            if (used_cnt_r < count_r) begin
              used_cnt_nxt = used_cnt_r + 1'b1;
            end
            alloc_tot_nxt         = alloc_tot_r + 32'd1;
            res_nxt.frame_out     = 8'(fq_rd_data);
          end
        end
        CMD_RELEASE: begin
          if (!fn_in_range) begin
            res_nxt.status = ST_BADFRAME;
          end else begin
            ot_wr_en          = 1'b1;
            // requeue only a frame that was actually in use
            if (fn_busy && 32'(level_r) < 32'(MAX_FRAMES)) begin
              fq_wr_en  = 1'b1;
              tail_nxt  = tail_inc;
              level_nxt = level_r + 1'b1;
            end
            if (free_cnt_r < count_r) begin
              free_cnt_nxt = free_cnt_r + 1'b1;
            end
            if (used_cnt_r != '0) begin
              used_cnt_nxt = used_cnt_r - 1'b1;
            end
            rel_tot_nxt       = rel_tot_r + 32'd1;
            res_nxt.frame_out = 8'(fn_idx);
          end
        end
        CMD_QUERY: begin
          if (!fn_in_range) begin
            res_nxt.status = ST_BADFRAME;
          end else begin
            res_nxt.frame_out  = 8'(fn_idx);
            res_nxt.frame_used = fn_busy;
            // a free frame always reports a zero owner
            if (fn_busy) begin
              res_nxt.owner_process = 16'(ot_rd_data[OWN_W-1:PAGE_BITS]);
              res_nxt.owner_page    = 20'(ot_rd_data[PAGE_BITS-1:0]);
            end
          end
        end
        default: begin
          res_nxt.status = ST_BADFRAME;
        end
      endcase
    end

    // clearing pass: frame idle with no owner, free list entry holds its index
    if (busy_r) begin
      fq_wr_en   = 1'b1;
      fq_wr_addr = clr_idx_r;
      fq_wr_data = clr_idx_r;
      ot_wr_en   = 1'b1;
      ot_wr_addr = clr_idx_r;
      ot_wr_data = '0;
    end

    res_nxt.free_frames       = 9'(free_cnt_nxt);
    res_nxt.used_frames       = 9'(used_cnt_nxt);
    res_nxt.allocations_total = alloc_tot_nxt;
    res_nxt.releases_total    = rel_tot_nxt;
  end

  // allocator state, reinitialized by reset or a frame count write
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      count_r     <= init_cnt;
      head_r      <= '0;
      tail_r      <= init_tail;
      level_r     <= init_cnt;
      free_cnt_r  <= init_cnt;
      used_cnt_r  <= '0;
      alloc_tot_r <= '0;
      rel_tot_r   <= '0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      level_r     <= level_nxt;
      free_cnt_r  <= free_cnt_nxt;
      used_cnt_r  <= used_cnt_nxt;
      alloc_tot_r <= alloc_tot_nxt;
      rel_tot_r   <= rel_tot_nxt;
    end
  end

  // handshake control and clearing pass sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      clr_idx_r    <= '0;
      s1_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      s1_vld_r     <= start && !busy_r;
      out_strobe_r <= s1_vld_r;
      if (cfg_we) begin
        busy_r    <= 1'b1;
        clr_idx_r <= '0;
      end else if (busy_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (32'(clr_idx_r) == 32'(MAX_FRAMES - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // transaction payload registers
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      s1_item_r <= in_item;
    end
    out_item_r <= res_nxt;
  end

  // free list storage, read at the head the next command will see
  pfa_free_queue #(
    .MAX_FRAMES (MAX_FRAMES),
    .IDX_W      (IDX_W)
  ) u_free_queue (
    .clk     (clk),
    .rd_addr (head_nxt),
    .wr_en   (fq_wr_en),
    .wr_addr (fq_wr_addr),
    .wr_data (fq_wr_data),
    .rd_data (fq_rd_data)
  );

  // frame table with busy bit, owner and page, read at the incoming frame number
  pfa_owner_table #(
    .MAX_FRAMES (MAX_FRAMES),
    .DATA_W     (TBL_W),
    .IDX_W      (IDX_W)
  ) u_owner_table (
    .clk     (clk),
    .rd_addr (IDX_W'(in_item.frame_number)),
    .wr_en   (ot_wr_en),
    .wr_addr (ot_wr_addr),
    .wr_data (ot_wr_data),
    .rd_data (ot_rd_data)
  );

  assign busy       = busy_r;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // every command in execution yields a result next cycle
  `ASSERT_NXT(a_result_follows, clk, rst_n, s1_vld_r, out_strobe_r)
  // counters stay within the configured frame count
  `ASSERT_IMP(a_cnt_bounds, clk, rst_n, 1'b1, (free_cnt_r <= count_r) && (used_cnt_r <= count_r))
  // the free list never holds more frames than are configured
  `ASSERT_IMP(a_level_bound, clk, rst_n, 1'b1, level_r <= count_r)

endmodule

/* test/pfa_checker.sv */
// checker for the frame allocator: tracks frame table state and compares every result
`timescale 1ns / 100ps

module pfa_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  pfa_pkg::pfa_in_t          in_item,
  input  logic                      out_strobe,
  input  pfa_pkg::pfa_out_t         out_item,
  input  logic                      cfg_we,
  input  logic [pfa_pkg::CFG_W-1:0] cfg_wdata,
  output int                        errors,
  output int                        pending
);
  import pfa_pkg::*;

  localparam int FRAMES_MAX = 256;

  // shadow copy of the allocator state
  logic [7:0]  ring_frame [FRAMES_MAX];
  logic [7:0]  ring_head;
  logic [7:0]  ring_tail;
  logic [8:0]  ring_level;
  logic        frame_taken [FRAMES_MAX];
  logic [15:0] frame_pid [FRAMES_MAX];
  logic [19:0] frame_vpage [FRAMES_MAX];
  logic [8:0]  frames_live;
  logic [8:0]  free_cnt;
  logic [8:0]  used_cnt;
  logic [31:0] alloc_cnt;
  logic [31:0] release_cnt;

  // results still owed by the block, oldest first
  pfa_out_t owed_results[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // load a frame count and rebuild table, free list and counters
  function automatic void load_frame_count(input logic [8:0] v);
    logic [8:0] n;
    n = v;
    if (n == 9'd0) n = 9'd1;
    if (n > 9'(FRAMES_MAX)) n = 9'(FRAMES_MAX);
    frames_live = n;
    for (int i = 0; i < FRAMES_MAX; i++) begin
      ring_frame[i]  = 8'(i);
      frame_taken[i] = 1'b0;
      frame_pid[i]   = '0;
      frame_vpage[i] = '0;
    end
    ring_head   = '0;
    ring_tail   = n[7:0];
    ring_level  = n;
    free_cnt    = n;
    used_cnt    = '0;
    alloc_cnt   = '0;
    release_cnt = '0;
  endfunction

  // apply one command to the shadow state and return the result it owes
  function automatic pfa_out_t run_command(input pfa_in_t c);
    pfa_out_t   r;
    logic [7:0] f;
    logic       was_taken;
    r = '0;
    r.status = ST_OK;
    f = c.frame_number[7:0];
    case (c.cmd)
      CMD_ALLOC: begin
        if (free_cnt == 9'd0 || ring_level == 9'd0) begin
          r.status = ST_NOFREE;
        end else begin
          f = ring_frame[ring_head];
          ring_head      = ring_head + 8'd1;
          ring_level     = ring_level - 9'd1;
          frame_taken[f] = 1'b1;
          frame_pid[f]   = c.process_id;
          frame_vpage[f] = c.page_number;
          free_cnt       = free_cnt - 9'd1;
          if (used_cnt < frames_live) used_cnt = used_cnt + 9'd1;
          alloc_cnt      = alloc_cnt + 32'd1;
          r.frame_out    = f;
        end
      end
      CMD_RELEASE: begin
        if (c.frame_number >= 10'(frames_live)) begin
          r.status = ST_BADFRAME;
        end else begin
          was_taken      = frame_taken[f];
          frame_taken[f] = 1'b0;
          frame_pid[f]   = '0;
          frame_vpage[f] = '0;
          // only a frame that was in use goes back on the free list
          if (was_taken && ring_level < 9'(FRAMES_MAX)) begin
            ring_frame[ring_tail] = f;
            ring_tail  = ring_tail + 8'd1;
            ring_level = ring_level + 9'd1;
          end
          if (free_cnt < frames_live) free_cnt = free_cnt + 9'd1;
          if (used_cnt > 9'd0) used_cnt = used_cnt - 9'd1;
          release_cnt = release_cnt + 32'd1;
          r.frame_out = f;
        end
      end
      CMD_QUERY: begin
        if (c.frame_number >= 10'(frames_live)) begin
          r.status = ST_BADFRAME;
        end else begin
          r.frame_out     = f;
          r.frame_used    = frame_taken[f];
          r.owner_process = frame_pid[f];
          r.owner_page    = frame_vpage[f];
        end
      end
      default: r.status = ST_BADFRAME;
    endcase
    r.free_frames       = free_cnt;
    r.used_frames       = used_cnt;
    r.allocations_total = alloc_cnt;
    r.releases_total    = release_cnt;
    return r;
  endfunction

  // one line per mismatch
  task automatic report(input string msg);
    errors++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  task automatic compare_result(input pfa_out_t got, input pfa_out_t want);
    check_field("status", 32'(got.status), 32'(want.status));
    check_field("frame_out", 32'(got.frame_out), 32'(want.frame_out));
    check_field("frame_used", 32'(got.frame_used), 32'(want.frame_used));
    check_field("owner_process", 32'(got.owner_process), 32'(want.owner_process));
    check_field("owner_page", 32'(got.owner_page), 32'(want.owner_page));
    check_field("free_frames", 32'(got.free_frames), 32'(want.free_frames));
    check_field("used_frames", 32'(got.used_frames), 32'(want.used_frames));
    check_field("allocations_total", got.allocations_total, want.allocations_total);
    check_field("releases_total", got.releases_total, want.releases_total);
  endtask

  // watch both channels and the register port at every edge
  always @(posedge clk) begin
    pfa_out_t want;
    if (!rst_n) begin
      load_frame_count(9'(FRAME_COUNT_RST));
      owed_results.delete();
    end else begin
      if (out_strobe) begin
        if (owed_results.size() == 0) begin
          report("result transaction with no command outstanding");
        end else begin
          want = owed_results.pop_front();
          compare_result(out_item, want);
        end
      end
      if (cfg_we) load_frame_count(cfg_wdata);
      if (start && !busy) owed_results.push_back(run_command(in_item));
    end
    pending = owed_results.size();
  end

endmodule

/* test/testbench.sv */
// testbench top for the frame allocator: clock, reset, command stimulus and verdict
`timescale 1ns / 100ps

module testbench;
  import pfa_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int PHASE_ITEMS = 110;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  pfa_in_t          in_item;
  logic             out_strobe;
  pfa_out_t         out_item;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int               errors;
  int               pending;
  int               frames_now;
  bit               calm;

  physical_frame_allocator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  pfa_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .errors     (errors),
    .pending    (pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic pfa_in_t make_cmd(input logic [1:0] c, input logic [15:0] pid,
                                       input logic [19:0] page, input logic [9:0] fn);
    pfa_in_t it;
    it.cmd          = c;
    it.process_id   = pid;
    it.page_number  = page;
    it.frame_number = fn;
    return it;
  endfunction

  // mostly allocate and release in range, some queries, stray frames and bad codes
  function automatic pfa_in_t random_command();
    int          pick;
    logic [1:0]  c;
    logic [9:0]  fn;
    pick = $urandom_range(0, 99);
    if (pick < 45)      c = CMD_ALLOC;
    else if (pick < 80) c = CMD_RELEASE;
    else if (pick < 96) c = CMD_QUERY;
    else                c = CMD_UNKNOWN;
    if ($urandom_range(0, 99) < 85) fn = 10'($urandom_range(0, frames_now - 1));
    else                            fn = 10'($urandom_range(0, 1023));
    return make_cmd(c, 16'($urandom_range(0, 16'hFFFF)),
                    20'($urandom_range(0, 20'hFFFFF)), fn);
  endfunction

  // one command transaction, with an occasional idle burst ahead of it
  task automatic send(input pfa_in_t it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // stop issuing and wait until every owed result has come back
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_frames(input logic [8:0] v);
    settle();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (v == 9'd0)        frames_now = 1;
    else if (v > 9'd256)  frames_now = 256;
    else                  frames_now = v;
  endtask

  // watchdog
  initial begin
    #20_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // stimulus
  initial begin
    logic [8:0] sizes [9];
    int         n;
    sizes = '{9'd3, 9'd256, 9'd2, 9'd511, 9'd8, 9'd300, 9'd64, 9'd1, 9'd17};
    calm       = 1'b0;
    frames_now = FRAME_COUNT_RST;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: full table after reset, field extremes, invalid frames
    send(make_cmd(CMD_ALLOC, 16'h0000, 20'h00000, 10'd0));
    send(make_cmd(CMD_ALLOC, 16'hFFFF, 20'hFFFFF, 10'h3FF));
    send(make_cmd(CMD_QUERY, 16'h0, 20'h0, 10'd1));
    send(make_cmd(CMD_QUERY, 16'h0, 20'h0, 10'd255));
    send(make_cmd(CMD_QUERY, 16'h0, 20'h0, 10'd256));
    send(make_cmd(CMD_QUERY, 16'h0, 20'h0, 10'd1023));
    send(make_cmd(CMD_RELEASE, 16'h0, 20'h0, 10'd0));
    // release of a frame that is already free
    send(make_cmd(CMD_RELEASE, 16'h0, 20'h0, 10'd0));
    send(make_cmd(CMD_QUERY, 16'h0, 20'h0, 10'd0));
    send(make_cmd(CMD_RELEASE, 16'h0, 20'h0, 10'd1023));
    send(make_cmd(CMD_UNKNOWN, 16'hFFFF, 20'hFFFFF, 10'd0));
    send(make_cmd(CMD_ALLOC, 16'h1234, 20'h56789, 10'd0));

    // single frame: exhaustion and counter saturation
    set_frames(9'd1);
    send(make_cmd(CMD_ALLOC, 16'hA5A5, 20'h5A5A5, 10'd0));
    send(make_cmd(CMD_ALLOC, 16'h0001, 20'h00001, 10'd0));
    send(make_cmd(CMD_QUERY, 16'h0, 20'h0, 10'd0));
    send(make_cmd(CMD_RELEASE, 16'h0, 20'h0, 10'd0));
    send(make_cmd(CMD_RELEASE, 16'h0, 20'h0, 10'd0));
    send(make_cmd(CMD_RELEASE, 16'h0, 20'h0, 10'd1));
    send(make_cmd(CMD_ALLOC, 16'h0002, 20'h00002, 10'd0));

    // zero count is taken as one
    set_frames(9'd0);
    send(make_cmd(CMD_ALLOC, 16'h0003, 20'h00003, 10'd0));
    send(make_cmd(CMD_ALLOC, 16'h0004, 20'h00004, 10'd0));
    send(make_cmd(CMD_QUERY, 16'h0, 20'h0, 10'd1));

    // random phases over several table sizes, no idling in the last one
    foreach (sizes[i]) begin
      set_frames(sizes[i]);
      calm = (i == 8);
      repeat (PHASE_ITEMS) send(random_command());
    end

    // drain with a bound, then let the pipeline go quiet
    start <= 1'b0;
    for (n = 0; n < 200 && pending != 0; n++) @(negedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
